// ===== rtl/assert_macros.svh =====
// assertion macros shared by the keyboard scancode decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define KSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ksd assertion failed");

// expression must never be true outside reset
`define KSD_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("ksd forbidden condition");

`else

`define KSD_ASSERT(lbl, clk, rstn, prop)
`define KSD_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/ksd_pkg.sv =====
// types, codes and scancode tables for the keyboard scancode decoder
package ksd_pkg;

  typedef struct packed {
    logic [7:0] scan_byte;
    logic       from_aux;
  } in_t;

  typedef struct packed {
    logic       pressed;
    logic [5:0] key_number;
    logic [5:0] modifier_bits;
  } out_t;

  typedef struct packed {
    logic [1:0] skip_left;
    logic       extended_pending;
    logic       release_pending;
    logic [5:0] modifiers_held;
  } state_t;

  typedef struct packed {
    logic emit;
    out_t res;
  } dec_t;

  // prefix bytes
  localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
  localparam logic [7:0] BYTE_EXTENDED = 8'hE0;
  localparam logic [7:0] BYTE_RELEASE  = 8'hF0;

  // bytes swallowed after the pause prefix
  localparam logic [1:0] SKIP_PAUSE = 2'd2;

  // key numbers with modifier meaning
  localparam logic [5:0] KEY_LSHIFT  = 6'd26;
  localparam logic [5:0] KEY_RSHIFT  = 6'd27;
  localparam logic [5:0] KEY_CONTROL = 6'd28;
  localparam logic [5:0] KEY_ALT     = 6'd29;
  localparam logic [5:0] KEY_LAST    = 6'd50;

  // modifier bit masks
  localparam logic [5:0] MASK_LSHIFT = 6'b000001;
  localparam logic [5:0] MASK_RSHIFT = 6'b000010;
  localparam logic [5:0] MASK_LCTL   = 6'b000100;
  localparam logic [5:0] MASK_RCTL   = 6'b001000;
  localparam logic [5:0] MASK_LMETA  = 6'b010000;
  localparam logic [5:0] MASK_RMETA  = 6'b100000;

  // table entries hold key number plus one, zero for no key
  function automatic logic [5:0] normal_lookup(input logic [6:0] code);
    logic [5:0] entry;
    unique case (code)
      7'h1E: entry = 6'd1;
      7'h30: entry = 6'd2;
      7'h2E: entry = 6'd3;
      7'h20: entry = 6'd4;
      7'h12: entry = 6'd5;
      7'h21: entry = 6'd6;
      7'h22: entry = 6'd7;
      7'h23: entry = 6'd8;
      7'h17: entry = 6'd9;
      7'h24: entry = 6'd10;
      7'h25: entry = 6'd11;
      7'h26: entry = 6'd12;
      7'h32: entry = 6'd13;
      7'h31: entry = 6'd14;
      7'h18: entry = 6'd15;
      7'h19: entry = 6'd16;
      7'h10: entry = 6'd17;
      7'h13: entry = 6'd18;
      7'h1F: entry = 6'd19;
      7'h14: entry = 6'd20;
      7'h16: entry = 6'd21;
      7'h2F: entry = 6'd22;
      7'h11: entry = 6'd23;
      7'h2D: entry = 6'd24;
      7'h15: entry = 6'd25;
      7'h2C: entry = 6'd26;
      7'h2A: entry = 6'd27;
      7'h36: entry = 6'd28;
      7'h1D: entry = 6'd29;
      7'h38: entry = 6'd30;
      7'h1C: entry = 6'd35;
      7'h39: entry = 6'd36;
      7'h0E: entry = 6'd37;
      7'h0F: entry = 6'd38;
      7'h01: entry = 6'd39;
      7'h3B: entry = 6'd40;
      7'h3C: entry = 6'd41;
      7'h3D: entry = 6'd42;
      7'h3E: entry = 6'd43;
      7'h3F: entry = 6'd44;
      7'h40: entry = 6'd45;
      7'h41: entry = 6'd46;
      7'h42: entry = 6'd47;
      7'h43: entry = 6'd48;
      7'h44: entry = 6'd49;
      7'h57: entry = 6'd50;
      7'h58: entry = 6'd51;
      default: entry = 6'd0;
    endcase
    return entry;
  endfunction

  function automatic logic [5:0] extended_lookup(input logic [6:0] code);
    logic [5:0] entry;
    unique case (code)
      7'h48: entry = 6'd31;
      7'h50: entry = 6'd32;
      7'h4B: entry = 6'd33;
      7'h4D: entry = 6'd34;
      7'h1D: entry = 6'd29;
      7'h38: entry = 6'd30;
      default: entry = 6'd0;
    endcase
    return entry;
  endfunction

endpackage

// ===== rtl/keyboard_scancode_decoder.sv =====
// keyboard scancode decoder top level: input register, decode, result register
//
//   channel | ports                          | content
//   --------+--------------------------------+-----------------------------------
//   in      | in_valid in_ready in_data      | scan_byte, from_aux
//   out     | out_valid out_ready out_data   | pressed, key_number, modifier_bits
//
// one byte per cycle sustained while out is not stalled; an accepted byte passes
// the input register, then decode into the result register
// bytes that make no result leave the input register even while out is stalled
// a stalled result holds the pipe only for the byte that would replace it
// rst_n clears prefix flags, skip count, held modifiers and both valid bits
`include "assert_macros.svh"

module keyboard_scancode_decoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ksd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ksd_pkg::out_t  out_data
);

  logic            s1_valid_r, s1_valid_nxt;
  ksd_pkg::in_t    s1_r;
  ksd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  ksd_pkg::out_t   out_r;
  ksd_pkg::dec_t   dec;
  logic            out_free;
  logic            s1_drain;
  logic            out_load;
  logic            in_fire;

  ksd_decode u_decode (
    .item   (s1_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .dec    (dec)
  );

  assign out_free = ~out_valid_r | out_ready;
  assign s1_drain = s1_valid_r & (~dec.emit | out_free);
  assign out_load = s1_drain & dec.emit;
  assign in_ready = ~s1_valid_r | s1_drain;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_drain) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_drain) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (out_load) begin
      out_r <= dec.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KSD_NEVER(a_skip_range, clk, rst_n, state_r.skip_left == 2'd3)
  `KSD_ASSERT(a_key_range, clk, rst_n, out_valid_r |-> out_r.key_number <= ksd_pkg::KEY_LAST)
  `KSD_ASSERT(a_mods_track, clk, rst_n, out_load |=> out_r.modifier_bits == state_r.modifiers_held)
  `KSD_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))

endmodule

// ===== rtl/ksd_decode.sv =====
// combinational byte decode: prefix handling, key lookup, modifier update
module ksd_decode (
  input  ksd_pkg::in_t    item,
  input  ksd_pkg::state_t st,
  output ksd_pkg::state_t st_nxt,
  output ksd_pkg::dec_t   dec
);

  logic [6:0] code;
  logic [5:0] entry;
  logic [5:0] key;
  logic [5:0] mask;
  logic       release_bit;

  assign code        = item.scan_byte[6:0];
  assign entry       = st.extended_pending ? ksd_pkg::extended_lookup(code)
                                           : ksd_pkg::normal_lookup(code);
  assign key         = entry - 6'd1;
  assign release_bit = item.scan_byte[7] | st.release_pending;

  // right-hand ctrl and alt come with the extended prefix
  always_comb begin
    unique case (key)
      ksd_pkg::KEY_LSHIFT:  mask = ksd_pkg::MASK_LSHIFT;
      ksd_pkg::KEY_RSHIFT:  mask = ksd_pkg::MASK_RSHIFT;
      ksd_pkg::KEY_CONTROL: mask = st.extended_pending ? ksd_pkg::MASK_RCTL
                                                       : ksd_pkg::MASK_LCTL;
      ksd_pkg::KEY_ALT:     mask = st.extended_pending ? ksd_pkg::MASK_RMETA
                                                       : ksd_pkg::MASK_LMETA;
      default:              mask = 6'd0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    dec    = '0;
    if (!item.from_aux) begin
      if (st.skip_left != 2'd0) begin
        st_nxt.skip_left = st.skip_left - 2'd1;
      end else if (item.scan_byte == ksd_pkg::BYTE_PAUSE) begin
        st_nxt.skip_left = ksd_pkg::SKIP_PAUSE;
      end else if (item.scan_byte == ksd_pkg::BYTE_EXTENDED) begin
        st_nxt.extended_pending = 1'b1;
      end else if (item.scan_byte == ksd_pkg::BYTE_RELEASE) begin
        st_nxt.release_pending = 1'b1;
      end else begin
        st_nxt.extended_pending = 1'b0;
        st_nxt.release_pending  = 1'b0;
        if (entry != 6'd0) begin
          if (release_bit) begin
            st_nxt.modifiers_held = st.modifiers_held & ~mask;
          end else begin
            st_nxt.modifiers_held = st.modifiers_held | mask;
          end
          dec.emit              = 1'b1;
          dec.res.pressed       = ~release_bit;
          dec.res.key_number    = key;
          dec.res.modifier_bits = st_nxt.modifiers_held;
        end
      end
    end
  end

endmodule

// ===== tb/keyboard_scancode_decoder_tb.sv =====
// self-checking testbench for keyboard_scancode_decoder with a scancode event scoreboard
module keyboard_scancode_decoder_tb;

  localparam int BYTE_TARGET = 1750;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef enum int {KEY_PRESS, RELEASE_BIT7, RELEASE_PREFIX, RELEASE_BOTH} key_action_t;
  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

  class scancode_tracker;
    logic [1:0]    skip_left;
    bit            ext_pending;
    bit            rel_pending;
    logic [5:0]    mods_held;
    ksd_pkg::out_t events_due[$];
    int unsigned   mismatches;
    int unsigned   events_checked;

    function new();
      skip_left = '0;
      ext_pending = 0;
      rel_pending = 0;
      mods_held = '0;
      mismatches = 0;
      events_checked = 0;
    endfunction

    static function int key_for(bit ext, logic [6:0] code);
      if (ext) begin
        case (code)
          7'h48: return 30;  7'h50: return 31;  7'h4B: return 32;
          7'h4D: return 33;  7'h1D: return 28;  7'h38: return 29;
          default: return -1;
        endcase
      end
      // F1 to F10 sit in one contiguous run
      if (code >= 7'h3B && code <= 7'h44) return int'(code) - 'h3B + 39;
      case (code)
        7'h1E: return 0;   7'h30: return 1;   7'h2E: return 2;   7'h20: return 3;
        7'h12: return 4;   7'h21: return 5;   7'h22: return 6;   7'h23: return 7;
        7'h17: return 8;   7'h24: return 9;   7'h25: return 10;  7'h26: return 11;
        7'h32: return 12;  7'h31: return 13;  7'h18: return 14;  7'h19: return 15;
        7'h10: return 16;  7'h13: return 17;  7'h1F: return 18;  7'h14: return 19;
        7'h16: return 20;  7'h2F: return 21;  7'h11: return 22;  7'h2D: return 23;
        7'h15: return 24;  7'h2C: return 25;  7'h2A: return 26;  7'h36: return 27;
        7'h1D: return 28;  7'h38: return 29;  7'h1C: return 34;  7'h39: return 35;
        7'h0E: return 36;  7'h0F: return 37;  7'h01: return 38;  7'h57: return 49;
        7'h58: return 50;
        default: return -1;
      endcase
    endfunction

    function void take_byte(ksd_pkg::in_t req);
      bit            is_release;
      bit            ext;
      int            key;
      logic [5:0]    mask;
      ksd_pkg::out_t ev;
      if (req.from_aux) return;
      if (skip_left != 2'd0) begin
        skip_left = skip_left - 2'd1;
        return;
      end
      if (req.scan_byte == ksd_pkg::BYTE_PAUSE) begin
        skip_left = ksd_pkg::SKIP_PAUSE;
        return;
      end
      if (req.scan_byte == ksd_pkg::BYTE_EXTENDED) begin
        ext_pending = 1;
        return;
      end
      if (req.scan_byte == ksd_pkg::BYTE_RELEASE) begin
        rel_pending = 1;
        return;
      end
      is_release = req.scan_byte[7] | rel_pending;
      rel_pending = 0;
      ext = ext_pending;
      ext_pending = 0;
      key = key_for(ext, req.scan_byte[6:0]);
      if (key < 0) return;
      mask = '0;
      if (key == int'(ksd_pkg::KEY_LSHIFT)) mask = ksd_pkg::MASK_LSHIFT;
      else if (key == int'(ksd_pkg::KEY_RSHIFT)) mask = ksd_pkg::MASK_RSHIFT;
      else if (key == int'(ksd_pkg::KEY_CONTROL))
        mask = ext ? ksd_pkg::MASK_RCTL : ksd_pkg::MASK_LCTL;
      else if (key == int'(ksd_pkg::KEY_ALT))
        mask = ext ? ksd_pkg::MASK_RMETA : ksd_pkg::MASK_LMETA;
      if (is_release) mods_held = mods_held & ~mask;
      else mods_held = mods_held | mask;
      ev.pressed = ~is_release;
      ev.key_number = key[5:0];
      ev.modifier_bits = mods_held;
      events_due.push_back(ev);
    endfunction

    function void check_event(ksd_pkg::out_t got);
      ksd_pkg::out_t want;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected key event: down=%0d key=%0d mods=%02h",
                   got.pressed, got.key_number, got.modifier_bits);
        return;
      end
      want = events_due.pop_front();
      events_checked++;
      if (got.pressed !== want.pressed || got.key_number !== want.key_number ||
          got.modifier_bits !== want.modifier_bits) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event mismatch: expected down=%0d key=%0d mods=%02h, %s",
                   want.pressed, want.key_number, want.modifier_bits,
                   $sformatf("got down=%0d key=%0d mods=%02h",
                             got.pressed, got.key_number, got.modifier_bits));
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  ksd_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ksd_pkg::out_t out_data;

  scancode_tracker tracker = new();
  int          key_bytes = 0;
  int          mouse_bytes = 0;
  int          pause_seqs = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          phase_left = 0;

  keyboard_scancode_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(in_data);
      if (out_valid && out_ready) tracker.check_event(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("keyboard_scancode_decoder verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver picks a new stall pattern each time its random phase count runs out
  always @(posedge clk) begin
    if (phase_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      phase_left <= $urandom_range(20, 80);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:      out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_req(logic [7:0] b, bit aux);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= '{scan_byte: b, from_aux: aux};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (aux) mouse_bytes++;
    else key_bytes++;
  endtask

  task automatic maybe_mouse();
    if ($urandom_range(0, 9) == 0) send_req(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_key(bit ext, logic [6:0] code, key_action_t action);
    if (ext) begin
      send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);
      maybe_mouse();
    end
    if (action == RELEASE_PREFIX || action == RELEASE_BOTH) begin
      send_req(ksd_pkg::BYTE_RELEASE, 1'b0);
      maybe_mouse();
    end
    send_req({action == RELEASE_BIT7 || action == RELEASE_BOTH, code}, 1'b0);
  endtask

  function automatic logic [6:0] pick_code(bit ext);
    logic [6:0] code;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: code = ext ? 7'h1D : 7'h2A;
        1: code = ext ? 7'h38 : 7'h36;
        2: code = 7'h1D;
        default: code = 7'h38;
      endcase
    end else if (ext) begin
      case ($urandom_range(0, 3))
        0: code = 7'h48;
        1: code = 7'h50;
        2: code = 7'h4B;
        default: code = 7'h4D;
      endcase
    end else begin
      do code = 7'($urandom_range(1, 'h58));
      while (scancode_tracker::key_for(1'b0, code) < 0);
    end
    return code;
  endfunction

  function automatic logic [7:0] pick_any_byte();
    case ($urandom_range(0, 5))
      0: return ksd_pkg::BYTE_EXTENDED;
      1: return ksd_pkg::BYTE_RELEASE;
      2: return ksd_pkg::BYTE_PAUSE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int kind;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sample keys, every modifier, prefixes, mouse bytes and unknown codes
    send_req(8'h1E, 1'b0);  send_req(8'h9E, 1'b0);
    send_req(8'h2A, 1'b0);  send_req(8'h36, 1'b0);
    send_req(8'h1D, 1'b0);  send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);  send_req(8'h1D, 1'b0);
    send_req(8'h38, 1'b0);  send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);  send_req(8'h38, 1'b0);
    send_req(ksd_pkg::BYTE_RELEASE, 1'b0);  send_req(8'hB6, 1'b0);
    send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);  send_req(8'h1E, 1'b1);  send_req(8'h9D, 1'b0);
    send_req(8'h58, 1'b0);
    send_req(ksd_pkg::BYTE_PAUSE, 1'b0);  send_req(8'hFF, 1'b1);
    send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);
    send_req(ksd_pkg::BYTE_RELEASE, 1'b0);
    send_req(ksd_pkg::BYTE_RELEASE, 1'b0);  send_req(8'h00, 1'b0);
    send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);  send_req(ksd_pkg::BYTE_EXTENDED, 1'b0);
    send_req(8'hC8, 1'b0);
    send_req(8'h7F, 1'b0);
    pause_seqs++;

    while (key_bytes + mouse_bytes < BYTE_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_key(1'b0, pick_code(1'b0), key_action_t'($urandom_range(0, 3)));
      end else if (kind < 72) begin
        send_key(1'b1, pick_code(1'b1), key_action_t'($urandom_range(0, 3)));
      end else if (kind < 78) begin
        send_req(ksd_pkg::BYTE_PAUSE, 1'b0);
        maybe_mouse();
        send_req(pick_any_byte(), 1'b0);
        send_req(pick_any_byte(), 1'b0);
        pause_seqs++;
      end else if (kind < 84) begin
        send_req(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 91) begin
        n = $urandom_range(1, 3);
        repeat (n) send_req($urandom_range(0, 1) ? ksd_pkg::BYTE_EXTENDED
                                                 : ksd_pkg::BYTE_RELEASE, 1'b0);
        send_req(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_req(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (tracker.events_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d key events from %0d keyboard bytes, %0d mouse bytes dropped",
             tracker.events_checked, key_bytes, mouse_bytes);
    $display("covered %0d pause sequences, prefix chains, unknown codes and stall phases",
             pause_seqs);
    if (tracker.mismatches == 0 && tracker.events_due.size() == 0) begin
      $display("keyboard_scancode_decoder verification clean");
    end else begin
      $display("%0d mismatches, %0d events never seen",
               tracker.mismatches, tracker.events_due.size());
      $display("keyboard_scancode_decoder verification failed");
    end
    $finish;
  end
endmodule
